// ----- src/rmat_pkg.sv -----
`timescale 1ns / 1ps
// Shared command codes, port widths and engine status type for the range max tree.
package rmat_pkg;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 10;
    localparam int VALUE_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Status an engine reports to the top level each cycle.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic done;
    } eng_stat_t;

endpackage

// ----- src/rmat_node_ram.sv -----
`timescale 1ns / 1ps
// Node memory: one write port and one read port with registered read data.
module rmat_node_ram #(
    parameter int WIDTH = 27,
    parameter int AW    = 11
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [1 << AW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/rmat_update.sv -----
`timescale 1ns / 1ps
// Point write/clear engine: walks down to the leaf, then merges back up to the root.
module rmat_update #(
    parameter int LEAVES = 1024,
    parameter int SW     = 10,
    parameter int VW     = 16,
    parameter int NW     = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic                  clear_slot,
    input  logic [SW-1:0]         slot,
    input  logic [VW-1:0]         value,
    input  logic [VW+SW:0]        rd_data,
    output rmat_pkg::eng_stat_t   stat,
    output logic [NW-1:0]         rd_addr,
    output logic [NW-1:0]         wr_addr,
    output logic [VW+SW:0]        wr_data
);

    localparam logic [SW-1:0] LAST = SW'(LEAVES - 1);
    localparam logic [NW-1:0] ROOT = NW'(1);

    typedef struct packed {
        logic          valid;
        logic [VW-1:0] value;
        logic [SW-1:0] slot;
    } node_t;

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_DESC = 3'b010,
        U_UP   = 3'b100
    } upd_state_t;

    // Ties go to the right child; a non-empty child beats an empty one.
    function automatic node_t pick(input node_t l, input node_t r);
        return (l.valid && (!r.valid || l.value > r.value)) ? l : r;
    endfunction

    upd_state_t    state_reg, state_next;
    logic [NW-1:0] k_reg;
    logic [SW-1:0] lo_reg, hi_reg, pos_reg;
    logic [VW-1:0] val_reg;
    logic          set_reg;
    node_t         cur_reg;

    logic [SW:0]   sum;
    logic [SW-1:0] mid;
    logic [NW-1:0] parent;
    node_t         leaf, sib, merged;

    assign sum    = (SW+1)'(lo_reg) + (SW+1)'(hi_reg);
    assign mid    = sum[SW:1];
    assign parent = {1'b0, k_reg[NW-1:1]};
    assign sib    = node_t'(rd_data);
    assign merged = k_reg[0] ? pick(sib, cur_reg) : pick(cur_reg, sib);

    always_comb
    begin
        leaf.valid = set_reg;
        leaf.value = set_reg ? val_reg : '0;
        leaf.slot  = set_reg ? pos_reg : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        stat       = '0;
        rd_addr    = '0;
        wr_addr    = '0;
        wr_data    = '0;
        unique case (state_reg)
            U_IDLE:
            begin
                if (go)
                begin
                    state_next = U_DESC;
                end
            end
            U_DESC:
            begin
                if (lo_reg == hi_reg)
                begin
                    stat.wr_en = 1'b1;
                    wr_addr    = k_reg;
                    wr_data    = leaf;
                    stat.rd_en = 1'b1;
                    rd_addr    = {k_reg[NW-1:1], ~k_reg[0]};
                    state_next = U_UP;
                end
            end
            U_UP:
            begin
                stat.wr_en = 1'b1;
                wr_addr    = parent;
                wr_data    = merged;
                if (parent == ROOT)
                begin
                    stat.done  = 1'b1;
                    state_next = U_IDLE;
                end
                else
                begin
                    stat.rd_en = 1'b1;
                    rd_addr    = {parent[NW-1:1], ~parent[0]};
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            k_reg   <= ROOT;
            lo_reg  <= '0;
            hi_reg  <= LAST;
            pos_reg <= slot;
            val_reg <= value;
            set_reg <= !clear_slot;
        end
        else if (state_reg == U_DESC)
        begin
            if (lo_reg == hi_reg)
            begin
                cur_reg <= leaf;
            end
            else if (pos_reg <= mid)
            begin
                k_reg  <= {k_reg[NW-2:0], 1'b0};
                hi_reg <= mid;
            end
            else
            begin
                k_reg  <= {k_reg[NW-2:0], 1'b1};
                lo_reg <= mid + 1'b1;
            end
        end
        else if (state_reg == U_UP)
        begin
            cur_reg <= merged;
            k_reg   <= parent;
        end
    end

endmodule

// ----- src/rmat_query.sv -----
`timescale 1ns / 1ps
// Range query engine: depth-first walk over covering nodes with a small stack.
module rmat_query #(
    parameter int LEAVES = 1024,
    parameter int SW     = 10,
    parameter int VW     = 16,
    parameter int NW     = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic                          empty,
    input  logic [SW-1:0]                 range_lo,
    input  logic [SW-1:0]                 range_hi,
    input  logic [VW+SW:0]                rd_data,
    output rmat_pkg::eng_stat_t           stat,
    output logic [NW-1:0]                 rd_addr,
    output logic                          result_valid,
    output logic                          found,
    output logic [rmat_pkg::SLOT_W-1:0]   max_slot,
    output logic [rmat_pkg::VALUE_W-1:0]  max_value
);

    localparam logic [SW-1:0] LAST = SW'(LEAVES - 1);
    localparam logic [NW-1:0] ROOT = NW'(1);
    localparam int SD  = SW + 1;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    typedef struct packed {
        logic          valid;
        logic [VW-1:0] value;
        logic [SW-1:0] slot;
    } node_t;

    typedef struct packed {
        logic [NW-1:0] k;
        logic [SW-1:0] lo;
        logic [SW-1:0] hi;
    } seg_t;

    typedef enum logic [2:0] {
        Q_IDLE = 3'b001,
        Q_WALK = 3'b010,
        Q_FIN  = 3'b100
    } qry_state_t;

    qry_state_t    state_reg, state_next;
    logic [NW-1:0] k_reg;
    logic [SW-1:0] lo_reg, hi_reg, a_reg, b_reg;
    logic [SPW-1:0] sp_reg;
    logic          pend_reg;
    node_t         best_reg;
    seg_t          stk_mem [SD];
    logic          result_valid_reg, found_reg;
    logic [rmat_pkg::SLOT_W-1:0]  max_slot_reg;
    logic [rmat_pkg::VALUE_W-1:0] max_value_reg;

    logic [SW:0]    sum;
    logic [SW-1:0]  mid;
    logic           covered, go_l, go_r;
    logic [SPW-1:0] sp_m1;
    seg_t           top_seg, right_seg;
    node_t          rd_node, best_comb;

    assign sum     = (SW+1)'(lo_reg) + (SW+1)'(hi_reg);
    assign mid     = sum[SW:1];
    assign covered = (a_reg <= lo_reg) && (hi_reg <= b_reg);
    assign go_l    = (a_reg <= mid);
    assign go_r    = (b_reg > mid);
    assign sp_m1   = sp_reg - 1'b1;
    assign top_seg = stk_mem[sp_m1[SIW-1:0]];
    assign rd_node = node_t'(rd_data);

    always_comb
    begin
        right_seg.k  = {k_reg[NW-2:0], 1'b1};
        right_seg.lo = mid + 1'b1;
        right_seg.hi = hi_reg;
    end

    // Segments arrive left to right; a later one wins only if strictly greater.
    always_comb
    begin
        if (pend_reg && rd_node.valid && (!best_reg.valid || rd_node.value > best_reg.value))
        begin
            best_comb = rd_node;
        end
        else
        begin
            best_comb = best_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        stat       = '0;
        rd_addr    = k_reg;
        unique case (state_reg)
            Q_IDLE:
            begin
                if (go)
                begin
                    state_next = empty ? Q_FIN : Q_WALK;
                end
            end
            Q_WALK:
            begin
                if (covered)
                begin
                    stat.rd_en = 1'b1;
                    if (sp_reg == '0)
                    begin
                        state_next = Q_FIN;
                    end
                end
            end
            Q_FIN:
            begin
                stat.done  = 1'b1;
                state_next = Q_IDLE;
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= Q_IDLE;
            sp_reg           <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pend_reg         <= (state_reg == Q_WALK) && covered;
            result_valid_reg <= (state_reg == Q_FIN);
            if (go)
            begin
                sp_reg <= '0;
            end
            else if (state_reg == Q_WALK)
            begin
                if (covered)
                begin
                    if (sp_reg != '0)
                    begin
                        sp_reg <= sp_m1;
                    end
                end
                else if (go_l && go_r)
                begin
                    sp_reg <= sp_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg    <= range_lo;
            b_reg    <= range_hi;
            k_reg    <= ROOT;
            lo_reg   <= '0;
            hi_reg   <= LAST;
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_comb;
            if (state_reg == Q_WALK)
            begin
                if (covered)
                begin
                    if (sp_reg != '0)
                    begin
                        k_reg  <= top_seg.k;
                        lo_reg <= top_seg.lo;
                        hi_reg <= top_seg.hi;
                    end
                end
                else if (go_l)
                begin
                    if (go_r)
                    begin
                        stk_mem[sp_reg[SIW-1:0]] <= right_seg;
                    end
                    k_reg  <= {k_reg[NW-2:0], 1'b0};
                    hi_reg <= mid;
                end
                else
                begin
                    k_reg  <= right_seg.k;
                    lo_reg <= right_seg.lo;
                end
            end
        end
        if (state_reg == Q_FIN)
        begin
            found_reg     <= best_comb.valid;
            max_slot_reg  <= best_comb.valid ? rmat_pkg::SLOT_W'(best_comb.slot) : '0;
            max_value_reg <= best_comb.valid ? rmat_pkg::VALUE_W'(best_comb.value) : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign max_slot     = max_slot_reg;
    assign max_value    = max_value_reg;

endmodule

// ----- src/range_max_argmax_tree.sv -----
`timescale 1ns / 1ps
// Top level of the range maximum / argmax segment tree with point write and clear.
//
// Commands are taken on a rising edge with start high and busy low: write a value to a
// slot, clear a slot to empty, or query the maximum over an inclusive slot range. Only a
// query produces a result, shown for exactly one cycle with result_valid high; there is no
// way to hold it off, so the receiver must take it in that cycle. The tree nodes live in
// one memory with one write and one read port and registered read data; busy stays high
// until a command has finished. A write or clear first walks down to the leaf, then
// goes back up to the root with a read-sibling/merge/write-parent step per level. A
// query visits tree nodes depth first and reads each covering node; the result appears
// in the same cycle that busy drops. Writes and clears to a slot at or above LEAVES and
// the unused command code are dropped without going busy. With D = ceil(log2(LEAVES)),
// after reset the block runs a clearing pass over all 2^(D+1) node entries, with busy
// held high the whole time.
module range_max_argmax_tree #(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rmat_pkg::CMD_W-1:0]    command,
    input  logic [rmat_pkg::SLOT_W-1:0]   slot_index,
    input  logic [rmat_pkg::SLOT_W-1:0]   range_high,
    input  logic [rmat_pkg::VALUE_W-1:0]  slot_value,
    output logic                          result_valid,
    output logic                          found,
    output logic [rmat_pkg::SLOT_W-1:0]   max_slot,
    output logic [rmat_pkg::VALUE_W-1:0]  max_value
);

    // Slot, node address and stored value widths all follow from the parameters.
    localparam int SW     = $clog2(LEAVES);
    localparam int NW     = SW + 1;
    localparam int VW     = (VALUE_BITS < rmat_pkg::VALUE_W) ? VALUE_BITS : rmat_pkg::VALUE_W;
    localparam int NODE_W = 1 + VW + SW;
    localparam int CW     = ((SW > rmat_pkg::SLOT_W) ? SW : rmat_pkg::SLOT_W) + 1;
    localparam logic [CW-1:0] LAST_C = CW'(LEAVES - 1);

    typedef enum logic [3:0] {
        T_CLEAR = 4'b0001,
        T_IDLE  = 4'b0010,
        T_UPD   = 4'b0100,
        T_QRY   = 4'b1000
    } top_state_t;

    top_state_t     state_reg, state_next;
    logic [NW-1:0]  clr_addr_reg;

    rmat_pkg::cmd_t cmd_in;
    logic           accept, slot_ok, q_empty, upd_go, qry_go;
    logic [CW-1:0]  lo_c, hi_in_c, hi_c;

    rmat_pkg::eng_stat_t upd_stat, qry_stat;
    logic [NW-1:0]     upd_rd_addr, upd_wr_addr, qry_rd_addr;
    logic [NODE_W-1:0] upd_wr_data;

    logic              mem_wr_en, mem_rd_en;
    logic [NW-1:0]     mem_wr_addr, mem_rd_addr;
    logic [NODE_W-1:0] mem_wr_data, mem_rd_data;

    // Command decode. The query's high bound is clamped to the last slot; a low bound
    // past the last slot or above the clamped high bound gives an empty range.
    assign cmd_in  = rmat_pkg::cmd_t'(command);
    assign accept  = start && !busy;
    assign lo_c    = CW'(slot_index);
    assign hi_in_c = CW'(range_high);
    assign hi_c    = (hi_in_c > LAST_C) ? LAST_C : hi_in_c;
    assign slot_ok = (lo_c <= LAST_C);
    assign q_empty = !slot_ok || (lo_c > hi_c);
    assign upd_go  = accept && slot_ok &&
                     (cmd_in == rmat_pkg::CMD_WRITE || cmd_in == rmat_pkg::CMD_CLEAR);
    assign qry_go  = accept && (cmd_in == rmat_pkg::CMD_QUERY);

    assign busy = (state_reg != T_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_CLEAR:
            begin
                if (&clr_addr_reg)
                begin
                    state_next = T_IDLE;
                end
            end
            T_IDLE:
            begin
                if (upd_go)
                begin
                    state_next = T_UPD;
                end
                else if (qry_go)
                begin
                    state_next = T_QRY;
                end
            end
            T_UPD:
            begin
                if (upd_stat.done)
                begin
                    state_next = T_IDLE;
                end
            end
            T_QRY:
            begin
                if (qry_stat.done)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == T_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Memory port sharing. Only one engine runs at a time, so the read port goes to
    // whichever is active; the clearing pass owns the write port until it ends.
    assign mem_wr_en   = (state_reg == T_CLEAR) || upd_stat.wr_en;
    assign mem_wr_addr = (state_reg == T_CLEAR) ? clr_addr_reg : upd_wr_addr;
    assign mem_wr_data = (state_reg == T_CLEAR) ? '0 : upd_wr_data;
    assign mem_rd_en   = upd_stat.rd_en || qry_stat.rd_en;
    assign mem_rd_addr = (state_reg == T_QRY) ? qry_rd_addr : upd_rd_addr;

    rmat_node_ram #(
        .WIDTH (NODE_W),
        .AW    (NW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rmat_update #(
        .LEAVES (LEAVES),
        .SW     (SW),
        .VW     (VW),
        .NW     (NW)
    ) u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (upd_go),
        .clear_slot (cmd_in == rmat_pkg::CMD_CLEAR),
        .slot       (SW'(lo_c)),
        .value      (VW'(slot_value)),
        .rd_data    (mem_rd_data),
        .stat       (upd_stat),
        .rd_addr    (upd_rd_addr),
        .wr_addr    (upd_wr_addr),
        .wr_data    (upd_wr_data)
    );

    rmat_query #(
        .LEAVES (LEAVES),
        .SW     (SW),
        .VW     (VW),
        .NW     (NW)
    ) u_query (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (qry_go),
        .empty        (q_empty),
        .range_lo     (SW'(lo_c)),
        .range_hi     (SW'(hi_c)),
        .rd_data      (mem_rd_data),
        .stat         (qry_stat),
        .rd_addr      (qry_rd_addr),
        .result_valid (result_valid),
        .found        (found),
        .max_slot     (max_slot),
        .max_value    (max_value)
    );

    // A result strobe lasts one cycle and always follows a query.
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    a_strobe_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == T_QRY))
        else $error("result strobe without a query in progress");

    // The update walk never reads the node it is writing in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("node memory read and write hit the same entry");

    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_QRY) |-> !mem_wr_en)
        else $error("node memory written during a query");

endmodule

// ----- tb/range_tree_checker.sv -----
`timescale 1ns / 1ps
// Checker for the range max tree: it follows every command, predicts query answers and compares them.
module range_tree_checker #(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [rmat_pkg::CMD_W-1:0]    command,
    input  logic [rmat_pkg::SLOT_W-1:0]   slot_index,
    input  logic [rmat_pkg::SLOT_W-1:0]   range_high,
    input  logic [rmat_pkg::VALUE_W-1:0]  slot_value,
    input  logic                          result_valid,
    input  logic                          found,
    input  logic [rmat_pkg::SLOT_W-1:0]   max_slot,
    input  logic [rmat_pkg::VALUE_W-1:0]  max_value,
    output int unsigned                   mismatch_count,
    output int unsigned                   answers_pending
);

    typedef struct packed {
        logic                         found;
        logic [rmat_pkg::SLOT_W-1:0]  slot;
        logic [rmat_pkg::VALUE_W-1:0] value;
    } tree_answer_t;

    localparam logic [31:0] VALUE_MASK =
        (VALUE_BITS >= 32) ? 32'hFFFF_FFFF : (32'd1 << VALUE_BITS) - 32'd1;

    // Flat copy of the slots; the tree itself is rebuilt on the fly for each query.
    logic                         slot_full [LEAVES];
    logic [rmat_pkg::VALUE_W-1:0] slot_val  [LEAVES];
    tree_answer_t                 expected_answers [$];
    tree_answer_t                 due_answer;
    int unsigned                  failures;

    // Walks the covering segments left to right. Inside one segment the winner is the
    // rightmost maximum, since every node merge hands ties to its right child. Across
    // segments a later one only takes over when it is strictly greater.
    function automatic tree_answer_t range_argmax(input int unsigned a,
                                                  input int unsigned b_raw);
        int unsigned  span_lo [$];
        int unsigned  span_hi [$];
        int unsigned  b;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        tree_answer_t best;
        tree_answer_t seg;
        best = '0;
        b = (b_raw > LEAVES - 1) ? LEAVES - 1 : b_raw;
        if (a < LEAVES && a <= b)
        begin
            span_lo.insert(span_lo.size(), 0);
            span_hi.insert(span_hi.size(), LEAVES - 1);
            while (span_lo.size() != 0)
            begin
                lo = span_lo.pop_back();
                hi = span_hi.pop_back();
                if (a <= lo && hi <= b)
                begin
                    seg = '0;
                    for (int unsigned s = lo; s <= hi; s++)
                    begin
                        if (slot_full[s] && (!seg.found || slot_val[s] >= seg.value))
                        begin
                            seg.found = 1'b1;
                            seg.slot  = s[rmat_pkg::SLOT_W-1:0];
                            seg.value = slot_val[s];
                        end
                    end
                    if (seg.found && (!best.found || seg.value > best.value))
                        best = seg;
                end
                else
                begin
                    mid = (lo + hi) >> 1;
                    // The right half goes on the stack first so the left half is visited first.
                    if (b > mid)
                    begin
                        span_lo.insert(span_lo.size(), mid + 1);
                        span_hi.insert(span_hi.size(), hi);
                    end
                    if (a <= mid)
                    begin
                        span_lo.insert(span_lo.size(), lo);
                        span_hi.insert(span_hi.size(), mid);
                    end
                end
            end
        end
        return best;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEAVES; i++)
            begin
                slot_full[i] = 1'b0;
                slot_val[i]  = '0;
            end
            expected_answers.delete();
            failures = 0;
            mismatch_count  <= 0;
            answers_pending <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error({"query answer with no query outstanding: ",
                            "found %0d, max_slot %0d, max_value %0d"},
                           found, max_slot, max_value);
                    failures++;
                end
                else
                begin
                    due_answer = expected_answers.pop_front();
                    if (found !== due_answer.found)
                    begin
                        $error("found: expected %0d, got %0d", due_answer.found, found);
                        failures++;
                    end
                    if (max_slot !== due_answer.slot)
                    begin
                        $error("max_slot: expected %0d, got %0d", due_answer.slot, max_slot);
                        failures++;
                    end
                    if (max_value !== due_answer.value)
                    begin
                        $error("max_value: expected %0d, got %0d", due_answer.value, max_value);
                        failures++;
                    end
                end
            end

            if (start && !busy)
            begin
                case (command)
                    rmat_pkg::CMD_WRITE:
                        if (slot_index < LEAVES)
                        begin
                            slot_full[slot_index] = 1'b1;
                            slot_val[slot_index]  =
                                slot_value & VALUE_MASK[rmat_pkg::VALUE_W-1:0];
                        end
                    rmat_pkg::CMD_CLEAR:
                        if (slot_index < LEAVES)
                        begin
                            slot_full[slot_index] = 1'b0;
                            slot_val[slot_index]  = '0;
                        end
                    rmat_pkg::CMD_QUERY:
                        expected_answers.insert(expected_answers.size(),
                                                range_argmax(slot_index, range_high));
                    default:
                        ;
                endcase
            end

            mismatch_count  <= failures;
            answers_pending <= expected_answers.size();
        end
    end

endmodule

// ----- tb/tb_range_max_argmax_tree.sv -----
`timescale 1ns / 1ps
// Testbench top for the range max tree: command stimulus, the block, its checker and the verdict.
module tb_range_max_argmax_tree;

    localparam int LEAVES     = 1024;
    localparam int VALUE_BITS = 16;
    localparam int LAST_SLOT  = LEAVES - 1;
    localparam int TOP_VALUE  = (1 << rmat_pkg::VALUE_W) - 1;
    localparam int RANDOM_ITEMS = 800;
    // The last stretch of the run is sent back to back, with no idle cycles at all.
    localparam int QUIET_TAIL   = 100;
    // Drain wait after the last answer; it is well above what the slowest query needs.
    localparam int DRAIN_CYCLES = 60;

    // All inputs of the block start at known values before the first edge.
    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                start        = 1'b0;
    logic [rmat_pkg::CMD_W-1:0]          command      = rmat_pkg::CMD_NONE;
    logic [rmat_pkg::SLOT_W-1:0]         slot_index   = '0;
    logic [rmat_pkg::SLOT_W-1:0]         range_high   = '0;
    logic [rmat_pkg::VALUE_W-1:0]        slot_value   = '0;
    logic                                busy;
    logic                                result_valid;
    logic                                found;
    logic [rmat_pkg::SLOT_W-1:0]         max_slot;
    logic [rmat_pkg::VALUE_W-1:0]        max_value;
    int unsigned                         mismatch_count;
    int unsigned                         answers_pending;

    // Base of a 64-slot window that much of the random traffic is aimed at, so that writes
    // pile up where the queries look and ties between equal values are common.
    int unsigned         window_base;

    always #2 clk = ~clk;

    range_max_argmax_tree #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .slot_index   (slot_index),
        .range_high   (range_high),
        .slot_value   (slot_value),
        .result_valid (result_valid),
        .found        (found),
        .max_slot     (max_slot),
        .max_value    (max_value)
    );

    range_tree_checker #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .slot_index      (slot_index),
        .range_high      (range_high),
        .slot_value      (slot_value),
        .result_valid    (result_valid),
        .found           (found),
        .max_slot        (max_slot),
        .max_value       (max_value),
        .mismatch_count  (mismatch_count),
        .answers_pending (answers_pending)
    );

    // Presents one command and returns at the edge where the transfer happens. Start is
    // left high, so a following call keeps it high without a glitch; every input is
    // assigned once per time step. All block outputs change only after the edge, so the
    // busy that is read here is the value the block itself sampled.
    task automatic issue_command(input rmat_pkg::cmd_t op, input int unsigned lo,
                                 input int unsigned hi, input int unsigned value);
        start      <= 1'b1;
        command    <= op;
        slot_index <= lo[rmat_pkg::SLOT_W-1:0];
        range_high <= hi[rmat_pkg::SLOT_W-1:0];
        slot_value <= value[rmat_pkg::VALUE_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drops start for a burst of idle cycles. The payload carries noise meanwhile, which
    // the block must not pick up.
    task automatic pause_sender(input int unsigned cycles);
        start      <= 1'b0;
        command    <= rmat_pkg::CMD_W'($urandom_range(0, 3));
        slot_index <= rmat_pkg::SLOT_W'($urandom_range(0, LAST_SLOT));
        range_high <= rmat_pkg::SLOT_W'($urandom_range(0, LAST_SLOT));
        slot_value <= rmat_pkg::VALUE_W'($urandom_range(0, TOP_VALUE));
        repeat (cycles)
            @(posedge clk);
    endtask

    // Values are drawn so that equal maxima happen often: a few tiny values, the two
    // extremes, and otherwise anything.
    function automatic int unsigned pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 7);
            1:       return $urandom_range(0, 1) ? TOP_VALUE : 0;
            default: return $urandom_range(0, TOP_VALUE);
        endcase
    endfunction

    function automatic int unsigned pick_slot();
        if ($urandom_range(0, 1))
            return window_base + $urandom_range(0, 63);
        return $urandom_range(0, LAST_SLOT);
    endfunction

    // Hard stop in case the block hangs; the slowest legal run is far shorter than this.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int unsigned lo;
        int unsigned hi;
        int unsigned pick;
        bit          idle_allowed;

        window_base = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The block runs its clearing pass first; the first transfer simply
        // waits for busy to drop.
        // A full-range query on a tree with nothing in it.
        issue_command(rmat_pkg::CMD_QUERY, 0, LAST_SLOT, 0);
        // A zero value is still a real entry, distinct from an empty slot.
        issue_command(rmat_pkg::CMD_WRITE, 0, 0, 0);
        issue_command(rmat_pkg::CMD_WRITE, LAST_SLOT, 0, TOP_VALUE);
        issue_command(rmat_pkg::CMD_QUERY, 0, LAST_SLOT, 0);
        issue_command(rmat_pkg::CMD_QUERY, 0, 0, 0);
        issue_command(rmat_pkg::CMD_QUERY, 5, 5, 0);
        // Three equal maxima: the root hands the tie to its right child, while a query
        // split across segments keeps the leftmost segment that holds the maximum.
        issue_command(rmat_pkg::CMD_WRITE, 511, 0, TOP_VALUE);
        issue_command(rmat_pkg::CMD_WRITE, 512, 0, TOP_VALUE);
        issue_command(rmat_pkg::CMD_QUERY, 0, LAST_SLOT, 0);
        issue_command(rmat_pkg::CMD_QUERY, 300, 700, 0);
        issue_command(rmat_pkg::CMD_CLEAR, LAST_SLOT, 0, 0);
        issue_command(rmat_pkg::CMD_QUERY, 0, LAST_SLOT, 0);
        // A reversed range is empty.
        issue_command(rmat_pkg::CMD_QUERY, 600, 500, 0);
        // Clearing a slot that is already empty changes nothing.
        issue_command(rmat_pkg::CMD_CLEAR, 700, 0, 0);
        // Overwriting with a smaller value must pull the maximum down.
        issue_command(rmat_pkg::CMD_WRITE, 512, 0, 100);
        issue_command(rmat_pkg::CMD_QUERY, 512, LAST_SLOT, 0);
        issue_command(rmat_pkg::CMD_QUERY, 0, LAST_SLOT, 0);
        // The unused command code with every payload bit set is ignored.
        issue_command(rmat_pkg::CMD_NONE, LAST_SLOT, LAST_SLOT, TOP_VALUE);
        issue_command(rmat_pkg::CMD_CLEAR, 0, 0, 0);
        issue_command(rmat_pkg::CMD_QUERY, 0, 10, 0);
        // Two equal maxima inside one covering segment: the tie goes to the right, to slot 511.
        issue_command(rmat_pkg::CMD_WRITE, 341, 0, TOP_VALUE);
        issue_command(rmat_pkg::CMD_QUERY, 1, LAST_SLOT - 1, 0);
        issue_command(rmat_pkg::CMD_QUERY, LAST_SLOT, LAST_SLOT, 0);

        // Random part. Idling is switched off in every third stretch of 80 items and in
        // the tail, so the block also sees long runs of back-to-back commands.
        for (int item = 0; item < RANDOM_ITEMS; item++)
        begin
            if (item % 64 == 0)
                window_base = $urandom_range(0, LEAVES - 64);
            pick = $urandom_range(0, 19);
            if (pick < 8)
                issue_command(rmat_pkg::CMD_WRITE, pick_slot(), $urandom_range(0, LAST_SLOT),
                              pick_value());
            else if (pick < 11)
                issue_command(rmat_pkg::CMD_CLEAR, pick_slot(), $urandom_range(0, LAST_SLOT),
                              $urandom_range(0, TOP_VALUE));
            else if (pick < 19)
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        lo = 0;
                        hi = LAST_SLOT;
                    end
                    1:
                    begin
                        lo = pick_slot();
                        hi = lo + $urandom_range(0, 15);
                    end
                    2:
                    begin
                        // Either order; a reversed pair gives an empty answer.
                        lo = $urandom_range(0, LAST_SLOT);
                        hi = $urandom_range(0, LAST_SLOT);
                    end
                    3:
                    begin
                        lo = window_base + $urandom_range(0, 31);
                        hi = window_base + $urandom_range(16, 63);
                    end
                    4:
                    begin
                        lo = $urandom_range(0, LAST_SLOT);
                        hi = LAST_SLOT;
                    end
                    default:
                    begin
                        lo = 0;
                        hi = $urandom_range(0, LAST_SLOT);
                    end
                endcase
                if (hi > LAST_SLOT)
                    hi = LAST_SLOT;
                issue_command(rmat_pkg::CMD_QUERY, lo, hi, $urandom_range(0, TOP_VALUE));
            end
            else
                issue_command(rmat_pkg::CMD_NONE, $urandom_range(0, LAST_SLOT),
                              $urandom_range(0, LAST_SLOT), $urandom_range(0, TOP_VALUE));

            idle_allowed = (item < RANDOM_ITEMS - QUIET_TAIL) && ((item / 80) % 3 != 2);
            if (idle_allowed && $urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 4));
        end

        // Everything has been sent. Wait for the last answers, then give the block time to
        // show any answer that nobody asked for.
        start <= 1'b0;
        @(posedge clk);
        while (answers_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && answers_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
